@@ rtl/ata_pkg.sv @@
// Shared types, widths and constant tables for the accelerometer tilt-angle unit.
package ata_pkg;

  localparam int RawW     = 16;
  localparam int SqW      = 32;
  localparam int SumW     = 33;
  localparam int RootW    = 31;
  localparam int OpndFrac = 14;
  localparam int AngW     = 8;
  localparam int XW       = 34;
  localparam int Lanes    = 3;

  localparam logic [RawW-1:0]       RawMax      = 16'hFFFF;
  localparam logic [RawW-1:0]       ThreshReset = 16'd17000;
  localparam logic signed [AngW-1:0] Deg90      = 8'sd90;

  localparam longint unsigned Nano      = 64'd1000000000;
  localparam longint unsigned ScaleNum  = 64'd13605;
  localparam longint unsigned Recip     = 64'd1152921504;
  localparam int              RecipPre  = 20;
  localparam int              RecipPost = 40;
  localparam int              RecipW    = 31;

  localparam longint unsigned AtanNanodeg [31] = '{
    64'd45000000000, 64'd26565051177, 64'd14036243468, 64'd7125016349,
    64'd3576334375,  64'd1789910608,  64'd895173710,   64'd447614171,
    64'd223810500,   64'd111905677,   64'd55952892,    64'd27976453,
    64'd13988227,    64'd6994114,     64'd3497057,     64'd1748528,
    64'd874264,      64'd437132,      64'd218566,      64'd109283,
    64'd54642,       64'd27321,       64'd13660,       64'd6830,
    64'd3415,        64'd1708,        64'd854,         64'd427,
    64'd213,         64'd107,         64'd53
  };

  // atan(2^-i) in degrees with frac fractional bits
  function automatic longint unsigned table_fixed(int i, int frac);
    longint unsigned n;
    n = AtanNanodeg[i];
    return ((n / Nano) << frac) + (((n % Nano) << frac) / Nano);
  endfunction

  typedef struct packed {
    logic [RawW-1:0] mag_x;
    logic [RawW-1:0] mag_y;
    logic            y_neg;
    logic            x_pos;
  } pre_t;

  typedef struct packed {
    logic                   neg;
    logic                   spec;
    logic signed [AngW-1:0] sval;
  } lane_t;

  typedef struct packed {
    lane_t [Lanes-1:0] lane;
    logic              degen;
  } side_t;

endpackage

@@ rtl/ata_root.sv @@
// Pipelined integer square root of two sums, one result bit per stage.
module ata_root (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [ata_pkg::SumW-1:0]      sum_a_i,
  input  logic [ata_pkg::SumW-1:0]      sum_b_i,
  input  ata_pkg::pre_t                 side_i,
  output logic                          valid_o,
  output logic [ata_pkg::RootW-1:0]     root_a_o,
  output logic [ata_pkg::RootW-1:0]     root_b_o,
  output ata_pkg::pre_t                 side_o
);

  localparam int Steps = ata_pkg::RootW;
  localparam int OpW   = 2 * Steps;
  localparam int RemW  = ata_pkg::RootW + 2;
  localparam int Pad   = OpW - ata_pkg::SumW - 2 * ata_pkg::OpndFrac;

  logic [RemW-1:0]           rem_q  [Steps][2];
  logic [ata_pkg::RootW-1:0] root_q [Steps][2];
  logic [OpW-1:0]            op_q   [Steps][2];
  logic                      vld_q  [Steps];
  ata_pkg::pre_t             side_q [Steps];

  for (genvar j = 0; j < Steps; j++) begin : g_step
    if (j == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[j] <= 1'b0;
        end else if (adv_i) begin
          vld_q[j] <= valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          side_q[j] <= side_i;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[j] <= 1'b0;
        end else if (adv_i) begin
          vld_q[j] <= vld_q[j-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          side_q[j] <= side_q[j-1];
        end
      end
    end

    for (genvar k = 0; k < 2; k++) begin : g_op
      logic [RemW-1:0]           rem_in;
      logic [ata_pkg::RootW-1:0] root_in;
      logic [OpW-1:0]            op_in;
      logic [RemW+1:0]           cur;
      logic [RemW+1:0]           trial;
      logic [RemW-1:0]           rem_d;
      logic [ata_pkg::RootW-1:0] root_d;

      if (j == 0) begin : g_src0
        assign rem_in  = '0;
        assign root_in = '0;
        assign op_in   = {{Pad{1'b0}}, (k == 0) ? sum_a_i : sum_b_i,
                          {(2 * ata_pkg::OpndFrac){1'b0}}};
      end else begin : g_srcn
        assign rem_in  = rem_q[j-1][k];
        assign root_in = root_q[j-1][k];
        assign op_in   = op_q[j-1][k];
      end

      always_comb begin
        cur   = {rem_in, op_in[OpW-1 -: 2]};
        trial = {1'b0, root_in, 2'b01};
        if (cur >= trial) begin
          rem_d  = RemW'(cur - trial);
          root_d = {root_in[ata_pkg::RootW-2:0], 1'b1};
        end else begin
          rem_d  = RemW'(cur);
          root_d = {root_in[ata_pkg::RootW-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          rem_q[j][k]  <= rem_d;
          root_q[j][k] <= root_d;
          op_q[j][k]   <= {op_in[OpW-3:0], 2'b00};
        end
      end
    end
  end

  assign valid_o  = vld_q[Steps-1];
  assign root_a_o = root_q[Steps-1][0];
  assign root_b_o = root_q[Steps-1][1];
  assign side_o   = side_q[Steps-1];

endmodule

@@ rtl/ata_cordic.sv @@
// Three-lane pipelined vectoring CORDIC with degree scaling and result register.
module ata_cordic #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              valid_i,
  input  logic [ata_pkg::RootW-1:0]         p_i [ata_pkg::Lanes],
  input  logic [ata_pkg::RootW-1:0]         q_i [ata_pkg::Lanes],
  input  ata_pkg::side_t                    side_i,
  output logic                              valid_o,
  output logic signed [ata_pkg::AngW-1:0]   angle_o [ata_pkg::Lanes],
  output logic                              degen_o
);

  localparam int Iters = FRAC_BITS + 1;
  localparam int XW    = ata_pkg::XW;
  localparam int ZW    = FRAC_BITS + 9;
  localparam int AW    = FRAC_BITS + 7;
  localparam int MW    = AW + 14;
  localparam int PW    = MW - ata_pkg::RecipPre + ata_pkg::RecipW;
  localparam int QW    = PW - ata_pkg::RecipPost;
  localparam int Post  = 6;
  localparam int DegW  = AW - FRAC_BITS;
  localparam logic signed [ZW-1:0] ZLim = ZW'(64'd90 << FRAC_BITS);

  logic signed [XW-1:0] x_q [Iters][ata_pkg::Lanes];
  logic signed [XW-1:0] y_q [Iters][ata_pkg::Lanes];
  logic signed [ZW-1:0] z_q [Iters][ata_pkg::Lanes];
  logic                 vld_q  [Iters];
  ata_pkg::side_t       side_q [Iters];

  // rotation stages
  for (genvar i = 0; i < Iters; i++) begin : g_iter
    localparam logic signed [ZW-1:0] Tab = ZW'(ata_pkg::table_fixed(i, FRAC_BITS));

    if (i == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[i] <= 1'b0;
        end else if (adv_i) begin
          vld_q[i] <= valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          side_q[i] <= side_i;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[i] <= 1'b0;
        end else if (adv_i) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          side_q[i] <= side_q[i-1];
        end
      end
    end

    for (genvar l = 0; l < ata_pkg::Lanes; l++) begin : g_lane
      logic signed [XW-1:0] x_in, y_in, x_d, y_d;
      logic signed [ZW-1:0] z_in, z_d;

      if (i == 0) begin : g_src0
        assign x_in = $signed({{(XW - ata_pkg::RootW){1'b0}}, q_i[l]});
        assign y_in = $signed({{(XW - ata_pkg::RootW){1'b0}}, p_i[l]});
        assign z_in = '0;
      end else begin : g_srcn
        assign x_in = x_q[i-1][l];
        assign y_in = y_q[i-1][l];
        assign z_in = z_q[i-1][l];
      end

      always_comb begin
        if (!y_in[XW-1]) begin
          x_d = x_in + (y_in >>> i);
          y_d = y_in - (x_in >>> i);
          z_d = z_in + Tab;
        end else begin
          x_d = x_in - (y_in >>> i);
          y_d = y_in + (x_in >>> i);
          z_d = z_in - Tab;
        end
      end

      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          x_q[i][l] <= x_d;
          y_q[i][l] <= y_d;
          z_q[i][l] <= z_d;
        end
      end
    end
  end

  // scaling stages: clamp, multiply, reciprocal estimate, back-multiply,
  // remainder, correct; the result register follows
  logic                 pv_q   [Post];
  ata_pkg::side_t       ps_q   [Post];
  logic [AW-1:0]        a_q    [Post][ata_pkg::Lanes];
  logic [MW-1:0]        m_q    [ata_pkg::Lanes];
  logic [MW-1:0]        m2_q   [ata_pkg::Lanes];
  logic [MW-1:0]        m3_q   [ata_pkg::Lanes];
  logic [PW-1:0]        pr_q   [ata_pkg::Lanes];
  logic [QW-1:0]        qe_q   [ata_pkg::Lanes];
  logic [QW-1:0]        qe2_q  [ata_pkg::Lanes];
  logic [MW-1:0]        qm_q   [ata_pkg::Lanes];
  logic [MW-1:0]        r_q    [ata_pkg::Lanes];
  logic [QW-1:0]        q_q    [ata_pkg::Lanes];
  logic signed [ata_pkg::AngW-1:0] ang_q [ata_pkg::Lanes];

  for (genvar s = 0; s < Post; s++) begin : g_post
    if (s == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          pv_q[s] <= 1'b0;
        end else if (adv_i) begin
          pv_q[s] <= vld_q[Iters-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          ps_q[s] <= side_q[Iters-1];
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          pv_q[s] <= 1'b0;
        end else if (adv_i) begin
          pv_q[s] <= pv_q[s-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          ps_q[s] <= ps_q[s-1];
        end
      end
    end
  end

  logic out_vld_q;
  logic out_degen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv_i) begin
      out_vld_q <= pv_q[Post-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_degen_q <= ps_q[Post-1].degen;
    end
  end

  for (genvar l = 0; l < ata_pkg::Lanes; l++) begin : g_scale
    logic signed [ZW-1:0] z_fin;
    logic [AW-1:0]        a_d;
    logic [MW-1:0]        r_fix;
    logic [AW-1:0]        scaled;
    logic [DegW-1:0]      deg;
    logic signed [ata_pkg::AngW-1:0] mag_s;
    ata_pkg::lane_t       ln;

    assign z_fin = z_q[Iters-1][l];

    always_comb begin
      if (z_fin[ZW-1]) begin
        a_d = '0;
      end else if (z_fin > ZLim) begin
        a_d = AW'(ZLim);
      end else begin
        a_d = AW'(z_fin);
      end
    end

    assign r_fix  = r_q[l];
    assign scaled = a_q[Post-1][l] - AW'(q_q[l]);
    assign deg    = scaled[AW-1:FRAC_BITS];
    assign mag_s  = $signed(ata_pkg::AngW'(deg));
    assign ln     = ps_q[Post-1].lane[l];

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        a_q[0][l] <= a_d;
        // multiply by the degree correction numerator
        a_q[1][l] <= a_q[0][l];
        m_q[l]    <= MW'(a_q[0][l] * MW'(ata_pkg::ScaleNum));
        // reciprocal estimate of the quotient by 1e9
        a_q[2][l] <= a_q[1][l];
        m2_q[l]   <= m_q[l];
        pr_q[l]   <= PW'(m_q[l][MW-1:ata_pkg::RecipPre]) * PW'(ata_pkg::Recip);
        // back-multiply the estimate
        a_q[3][l] <= a_q[2][l];
        m3_q[l]   <= m2_q[l];
        qe_q[l]   <= pr_q[l][PW-1:ata_pkg::RecipPost];
        qm_q[l]   <= MW'(pr_q[l][PW-1:ata_pkg::RecipPost] * MW'(ata_pkg::Nano));
        // remainder
        a_q[4][l] <= a_q[3][l];
        qe2_q[l]  <= qe_q[l];
        r_q[l]    <= m3_q[l] - qm_q[l];
        // estimate is low by at most two
        a_q[5][l] <= a_q[4][l];
        if (r_fix >= MW'(2 * ata_pkg::Nano)) begin
          q_q[l] <= qe2_q[l] + QW'(2);
        end else if (r_fix >= MW'(ata_pkg::Nano)) begin
          q_q[l] <= qe2_q[l] + QW'(1);
        end else begin
          q_q[l] <= qe2_q[l];
        end
        // whole degrees with sign or the zero-divisor value
        if (ln.spec) begin
          ang_q[l] <= ln.sval;
        end else if (ln.neg) begin
          ang_q[l] <= -mag_s;
        end else begin
          ang_q[l] <= mag_s;
        end
      end
    end

    assign angle_o[l] = ang_q[l];
  end

  assign valid_o = out_vld_q;
  assign degen_o = out_degen_q;

endmodule

@@ rtl/accel_tilt_angles_unit.sv @@
// Top level of the accelerometer tilt-angle unit: front end, root and CORDIC pipelines.
//
// Input channel: raw_x_i/raw_y_i/raw_z_i with in_valid_i; a transaction is taken
// at a clock edge with in_valid_i high and in_stall_o low. Each raw word is made
// signed against sign_threshold, then three angles in whole degrees and a
// degenerate flag come out on the output channel (out_valid_o / out_stall_i).
// Configuration: cfg_valid_i with cfg_data_i writes sign_threshold; cfg_ready_o
// is always high. Write it only while no transaction is in flight.
// Throughput: one transaction per cycle while out_stall_i does not hold back a
// result. The path from acceptance to out_valid_o runs through three front stages
// (sign, square, sum), 31 square-root stages (one root bit each), one lane
// set-up stage, FRAC_BITS+1 CORDIC rotations, six scaling stages and the
// result register.
// Stall: the whole pipeline advances together; when out_stall_i holds back a
// valid result, every stage holds and in_stall_o goes high, so nothing is
// dropped or repeated. Reset clears all valid bits and loads sign_threshold
// with 17000.
module accel_tilt_angles_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ata_pkg::RawW-1:0]        cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ata_pkg::RawW-1:0]        raw_x_i,
  input  logic [ata_pkg::RawW-1:0]        raw_y_i,
  input  logic [ata_pkg::RawW-1:0]        raw_z_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [ata_pkg::AngW-1:0] x_angle_o,
  output logic signed [ata_pkg::AngW-1:0] y_angle_o,
  output logic signed [ata_pkg::AngW-1:0] z_angle_o,
  output logic                            degenerate_o
);

  localparam int RawW = ata_pkg::RawW;

  logic [RawW-1:0] thr_q;
  logic            adv;

  // advance unless a finished result is held back
  assign adv         = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ata_pkg::ThreshReset;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // stage A: sign rule, magnitudes
  logic            a_vld_q;
  logic [RawW-1:0] a_mag_q [3];
  logic            a_yneg_q, a_xpos_q;
  logic [RawW-1:0] raw [3];

  assign raw[0] = raw_x_i;
  assign raw[1] = raw_y_i;
  assign raw[2] = raw_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_mag
    always_ff @(posedge clk_i) begin
      if (adv) begin
        // above threshold the reading is raw - 65535, magnitude 65535 - raw
        a_mag_q[k] <= (raw[k] > thr_q) ? (ata_pkg::RawMax - raw[k]) : raw[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_yneg_q <= (raw_y_i > thr_q) && (raw_y_i != ata_pkg::RawMax);
      a_xpos_q <= (raw_x_i <= thr_q) && (raw_x_i != '0);
    end
  end

  // stage B: squares
  logic                   b_vld_q;
  logic [ata_pkg::SqW-1:0] b_sq_q [3];
  ata_pkg::pre_t          b_pre_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv) begin
      b_vld_q <= a_vld_q;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_sq
    always_ff @(posedge clk_i) begin
      if (adv) begin
        b_sq_q[k] <= a_mag_q[k] * a_mag_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_pre_q.mag_x <= a_mag_q[0];
      b_pre_q.mag_y <= a_mag_q[1];
      b_pre_q.y_neg <= a_yneg_q;
      b_pre_q.x_pos <= a_xpos_q;
    end
  end

  // stage C: sums of squares
  logic                    c_vld_q;
  logic [ata_pkg::SumW-1:0] c_zx_q, c_zy_q;
  ata_pkg::pre_t           c_pre_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (adv) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_zx_q  <= {1'b0, b_sq_q[2]} + {1'b0, b_sq_q[0]};
      c_zy_q  <= {1'b0, b_sq_q[2]} + {1'b0, b_sq_q[1]};
      c_pre_q <= b_pre_q;
    end
  end

  // square roots
  logic                     r_vld;
  logic [ata_pkg::RootW-1:0] r_zx, r_zy;
  ata_pkg::pre_t            r_pre;

  ata_root u_root (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (c_vld_q),
    .sum_a_i  (c_zx_q),
    .sum_b_i  (c_zy_q),
    .side_i   (c_pre_q),
    .valid_o  (r_vld),
    .root_a_o (r_zx),
    .root_b_o (r_zy),
    .side_o   (r_pre)
  );

  // stage D: lane operands and zero-divisor handling
  logic [ata_pkg::RootW-1:0] d_p_q [ata_pkg::Lanes];
  logic [ata_pkg::RootW-1:0] d_q_q [ata_pkg::Lanes];
  logic                      d_vld_q;
  ata_pkg::side_t            d_side_q;
  logic [ata_pkg::RootW-1:0] lp [ata_pkg::Lanes];
  logic [ata_pkg::RootW-1:0] lq [ata_pkg::Lanes];
  logic                      nneg [ata_pkg::Lanes];
  logic                      rneg [ata_pkg::Lanes];
  ata_pkg::side_t            side_d;

  assign lp[0] = {r_pre.mag_y, {ata_pkg::OpndFrac{1'b0}}, 1'b0} >> 1;
  assign lq[0] = r_zx;
  assign lp[1] = {r_pre.mag_x, {ata_pkg::OpndFrac{1'b0}}, 1'b0} >> 1;
  assign lq[1] = r_zy;
  assign lp[2] = r_zx;
  assign lq[2] = {r_pre.mag_y, {ata_pkg::OpndFrac{1'b0}}, 1'b0} >> 1;

  assign nneg[0] = r_pre.y_neg;
  assign nneg[1] = r_pre.x_pos;
  assign nneg[2] = 1'b0;
  assign rneg[0] = r_pre.y_neg;
  assign rneg[1] = r_pre.x_pos;
  assign rneg[2] = r_pre.y_neg;

  always_comb begin
    side_d.degen = 1'b0;
    for (int l = 0; l < ata_pkg::Lanes; l++) begin
      side_d.lane[l].neg  = rneg[l];
      side_d.lane[l].spec = (lq[l] == '0) || (lp[l] == '0);
      if (lq[l] == '0 && lp[l] != '0) begin
        side_d.lane[l].sval = nneg[l] ? -ata_pkg::Deg90 : ata_pkg::Deg90;
      end else begin
        side_d.lane[l].sval = '0;
      end
      if (lq[l] == '0) begin
        side_d.degen = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (adv) begin
      d_vld_q <= r_vld;
    end
  end

  for (genvar l = 0; l < ata_pkg::Lanes; l++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (adv) begin
        d_p_q[l] <= lp[l];
        d_q_q[l] <= lq[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_side_q <= side_d;
    end
  end

  // arctangent, scaling and result register
  logic signed [ata_pkg::AngW-1:0] ang [ata_pkg::Lanes];

  ata_cordic #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (d_vld_q),
    .p_i     (d_p_q),
    .q_i     (d_q_q),
    .side_i  (d_side_q),
    .valid_o (out_valid_o),
    .angle_o (ang),
    .degen_o (degenerate_o)
  );

  assign x_angle_o = ang[0];
  assign y_angle_o = ang[1];
  assign z_angle_o = ang[2];

  // results stay within a quarter turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (x_angle_o >= -8'sd90 && x_angle_o <= 8'sd90 &&
                     y_angle_o >= -8'sd90 && y_angle_o <= 8'sd90 &&
                     z_angle_o >= -8'sd90 && z_angle_o <= 8'sd90))
    else $error("angle out of range");

  // finite ratios never reach a right angle on the x and z lanes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !degenerate_o) |->
      (x_angle_o != 8'sd90 && x_angle_o != -8'sd90 &&
       z_angle_o != 8'sd90 && z_angle_o != -8'sd90))
    else $error("right angle without zero divisor");

  // x and z angles share the sign of the y reading when no divisor is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !degenerate_o && x_angle_o < 0) |-> (z_angle_o <= 0))
    else $error("x and z angle signs disagree");

endmodule
